[rtl/core/isa_pkg.sv]
// isa_pkg: shared constants and types for the id slot allocator
// depends on nothing; used by the allocator, its checker and the bench
`timescale 1ns / 1ps

package isa_pkg;

  localparam int ENTRIES    = 1024;
  localparam int ELEM_WIDTH = 32;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  localparam int REQ_W  = 2;
  localparam int SLOT_W = 10;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int HW_W   = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_SET    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NO_ID = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

endpackage

[rtl/core/id_slot_allocator.sv]
// id_slot_allocator: slot table with reusable ids kept on a free list
// result: registered, shown in the cycle after the item is accepted
// throughput: one item per cycle if out_ready; an add that pops with more
//   than one id waiting drops in_ready (free list read refills cached head)
// reset: synchronous active low clears counts and handshake state; the
//   element store and free list rams are not cleared
`timescale 1ns / 1ps

module id_slot_allocator
  import isa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [SLOT_W-1:0] in_slot_id,
  input  logic [DATA_W-1:0] in_element_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] out_result_id,
  output logic [STAT_W-1:0] out_status,
  output logic [HW_W-1:0]   out_high_water,
  output logic [HW_W-1:0]   out_free_ids
);

  state_t                 state_r, state_nxt;
  logic                   out_valid_r;
  logic [SLOT_W-1:0]      rid_r, rid_nxt;
  status_t                status_r, status_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       mark_r, mark_nxt;
  logic [IDX_W-1:0]       head_r, head_nxt;

  logic                   in_fire;
  logic                   range_bad;

  logic                   st_we;
  logic [IDX_W-1:0]       st_addr;
  logic [ELEM_WIDTH-1:0]  st_wdata;

  logic                   fl_we;
  logic [IDX_W-1:0]       fl_waddr;
  logic [IDX_W-1:0]       fl_wdata;
  logic [IDX_W-1:0]       fl_raddr;
  logic [IDX_W-1:0]       fl_rdata;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign range_bad = 32'(in_slot_id) >= ENTRIES;

  always_comb begin
    state_nxt  = state_r;
    rid_nxt    = rid_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    mark_nxt   = mark_r;
    head_nxt   = head_r;
    st_we      = 1'b0;
    st_addr    = IDX_W'(in_slot_id);
    st_wdata   = ELEM_WIDTH'(in_element_data);
    fl_we      = 1'b0;
    fl_waddr   = cnt_r[IDX_W-1:0];
    fl_wdata   = IDX_W'(in_slot_id);
    fl_raddr   = IDX_W'(cnt_r - CNT_W'(1));

    if (state_r == S_POP) begin
      head_nxt  = fl_rdata;
      state_nxt = S_IDLE;
    end

    if (in_fire) begin
      rid_nxt    = in_slot_id;
      status_nxt = ST_OK;
      case (req_t'(in_req_type))
        REQ_ADD: begin
          if (cnt_r != '0) begin
            rid_nxt = SLOT_W'(head_r);
            cnt_nxt = cnt_r - CNT_W'(1);
            st_we   = 1'b1;
            st_addr = head_r;
            if (CNT_W'(head_r) + CNT_W'(1) > mark_r) begin
              mark_nxt = CNT_W'(head_r) + CNT_W'(1);
            end
            if (cnt_r > CNT_W'(1)) begin
              state_nxt = S_POP;
            end
          end else if (32'(mark_r) < ENTRIES) begin
            rid_nxt  = SLOT_W'(mark_r);
            st_we    = 1'b1;
            st_addr  = IDX_W'(mark_r);
            mark_nxt = mark_r + CNT_W'(1);
          end else begin
            rid_nxt    = '0;
            status_nxt = ST_NO_ID;
          end
        end
        REQ_SET: begin
          if (range_bad) begin
            status_nxt = ST_RANGE;
          end else begin
            st_we = 1'b1;
            if (CNT_W'(in_slot_id) + CNT_W'(1) > mark_r) begin
              mark_nxt = CNT_W'(in_slot_id) + CNT_W'(1);
            end
          end
        end
        REQ_REMOVE: begin
          if (range_bad) begin
            status_nxt = ST_RANGE;
          end else if (32'(cnt_r) >= ENTRIES) begin
            status_nxt = ST_FULL;
          end else begin
            fl_we    = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
            st_we    = 1'b1;
            st_wdata = '0;
            if (cnt_r == '0) begin
              head_nxt = IDX_W'(in_slot_id);
            end
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      mark_r      <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mark_r  <= mark_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rid_r    <= rid_nxt;
    status_r <= status_nxt;
    head_r   <= head_nxt;
  end

  isa_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_addr),
    .wr_data (st_wdata),
    .rd_addr (st_addr),
    .rd_data ()
  );

  isa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ENTRIES)
  ) u_free_list (
    .clk     (clk),
    .wr_en   (fl_we),
    .wr_addr (fl_waddr),
    .wr_data (fl_wdata),
    .rd_addr (fl_raddr),
    .rd_data (fl_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_result_id  = rid_r;
  assign out_status     = status_r;
  assign out_high_water = HW_W'(mark_r);
  assign out_free_ids   = HW_W'(cnt_r);

endmodule

[rtl/core/isa_ram.sv]
// isa_ram: generic single write port, single read port ram
// registered read; no dependencies
`timescale 1ns / 1ps

module isa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/isa_checker.sv]
// isa_checker: port level assertions for id_slot_allocator
// depends on isa_pkg; bound to the top level below
`timescale 1ns / 1ps

module isa_checker
  import isa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [REQ_W-1:0]  in_req_type,
  input logic [SLOT_W-1:0] in_slot_id,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] out_result_id,
  input logic [STAT_W-1:0] out_status,
  input logic [HW_W-1:0]   out_high_water,
  input logic [HW_W-1:0]   out_free_ids
);

  // an accepted item shows its result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_id)
      && $stable(out_status) && $stable(out_high_water) && $stable(out_free_ids))
    else $error("stalled result changed");

  // no free id only when nothing waits and every id is in use
  a_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_ID) |->
      (out_result_id == '0) && (out_free_ids == '0) && (out_high_water == HW_W'(ENTRIES)))
    else $error("no free id reported with ids left");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_free_ids == HW_W'(ENTRIES)))
    else $error("free list full reported below capacity");

  // every item but an add echoes its slot id
  a_range_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type != REQ_ADD) |=> out_result_id == $past(in_slot_id))
    else $error("slot id not echoed");

endmodule

bind id_slot_allocator isa_checker u_isa_checker (.*);

[bench/tb_top.sv]
// tb_top: self-checking bench for id_slot_allocator, with random idling on both sides
// depends on isa_pkg and id_slot_allocator; a local model of the id table predicts each result
`timescale 1ns / 1ps

module tb_top;
  import isa_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [SLOT_W-1:0] result_id;
    status_t           status;
    logic [HW_W-1:0]   high_water;
    logic [HW_W-1:0]   free_ids;
  } alloc_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [SLOT_W-1:0] in_slot_id = '0;
  logic [DATA_W-1:0] in_element_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] out_result_id;
  logic [STAT_W-1:0] out_status;
  logic [HW_W-1:0]   out_high_water;
  logic [HW_W-1:0]   out_free_ids;

  // local copy of the allocator state
  logic [IDX_W-1:0] waiting_ids [ENTRIES];
  int               waiting_count = 0;
  int               id_mark = 0;

  alloc_result_t awaited_results [$];
  int            bad_results = 0;
  int            quiet_cycles = 0;
  int            sink_hold = 0;
  bit            gaps_on = 1'b0;

  id_slot_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_slot_id      (in_slot_id),
    .in_element_data (in_element_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_id   (out_result_id),
    .out_status      (out_status),
    .out_high_water  (out_high_water),
    .out_free_ids    (out_free_ids)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic alloc_result_t apply_request(input logic [REQ_W-1:0] req,
                                                  input logic [SLOT_W-1:0] id);
    alloc_result_t r;
    int            pick;
    r.result_id = id;
    r.status    = ST_OK;
    case (req)
      REQ_ADD: begin
        if (waiting_count > 0) begin
          pick = int'(waiting_ids[0]);
          waiting_count--;
          waiting_ids[0] = waiting_ids[waiting_count];
          r.result_id = pick[SLOT_W-1:0];
          if (pick + 1 > id_mark) id_mark = pick + 1;
        end else if (id_mark < ENTRIES) begin
          r.result_id = id_mark[SLOT_W-1:0];
          id_mark++;
        end else begin
          r.result_id = '0;
          r.status    = ST_NO_ID;
        end
      end
      REQ_SET: begin
        if (int'(id) >= ENTRIES) r.status = ST_RANGE;
        else if (int'(id) + 1 > id_mark) id_mark = int'(id) + 1;
      end
      REQ_REMOVE: begin
        if (int'(id) >= ENTRIES) begin
          r.status = ST_RANGE;
        end else if (waiting_count >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          waiting_ids[waiting_count] = id[IDX_W-1:0];
          waiting_count++;
        end
      end
      default: ;
    endcase
    r.high_water = id_mark[HW_W-1:0];
    r.free_ids   = waiting_count[HW_W-1:0];
    return r;
  endfunction

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] id,
                           input logic [DATA_W-1:0] data);
    int gap;
    gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_slot_id      <= id;
    in_element_data <= data;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(apply_request(req, id));
  endtask

  // ids from zero up to eight past the high-water mark, anywhere with wide_pct percent chance
  function automatic logic [SLOT_W-1:0] near_id(input int wide_pct);
    int top;
    top = (id_mark + 8 > ENTRIES - 1) ? ENTRIES - 1 : id_mark + 8;
    if ($urandom_range(0, 99) < wide_pct) return SLOT_W'($urandom_range(0, ENTRIES - 1));
    return SLOT_W'($urandom_range(0, top));
  endfunction

  task automatic send_random(input int add_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) send_item(REQ_ADD, SLOT_W'($urandom_range(0, ENTRIES - 1)), $urandom);
    else if (pick < add_pct + 25) send_item(REQ_SET, near_id(0), $urandom);
    else if (pick < 96) send_item(REQ_REMOVE, near_id(30), $urandom);
    else send_item(REQ_UNUSED, SLOT_W'($urandom_range(0, ENTRIES - 1)), $urandom);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic test_basic_requests();
    gaps_on = 1'b0;
    send_item(REQ_ADD, 10'h3ff, 32'h0000_0000);
    send_item(REQ_ADD, 10'h000, 32'hffff_ffff);
    send_item(REQ_SET, 10'd5, 32'h1234_5678);
    send_item(REQ_SET, 10'd0, 32'h0000_0000);
    send_item(REQ_REMOVE, 10'd1, 32'h0);
    send_item(REQ_REMOVE, 10'd1, 32'h0);
    send_item(REQ_REMOVE, 10'd3, 32'h0);
    send_item(REQ_ADD, 10'd0, 32'hdead_beef);
    send_item(REQ_ADD, 10'd0, 32'h8000_0001);
    send_item(REQ_ADD, 10'd0, 32'h7fff_fffe);
    send_item(REQ_ADD, 10'd0, 32'h5555_aaaa);
    send_item(REQ_REMOVE, 10'd40, 32'hffff_ffff);
    send_item(REQ_ADD, 10'h3ff, 32'haaaa_5555);
    send_item(REQ_UNUSED, 10'h3ff, 32'hffff_ffff);
    send_item(REQ_UNUSED, 10'h000, 32'h0000_0000);
    send_item(REQ_REMOVE, 10'd0, 32'h0);
    send_item(REQ_REMOVE, 10'd7, 32'h0);
    send_item(REQ_REMOVE, 10'd2, 32'h0);
    send_item(REQ_ADD, 10'd0, 32'h0f0f_0f0f);
    send_item(REQ_SET, 10'd41, 32'hf0f0_f0f0);
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 12 == 0) gaps_on = $urandom_range(0, 3) != 0;
      if (i == count / 2) wait_for_results();
      send_random(35);
    end
  endtask

  task automatic test_no_free_id();
    gaps_on = 1'b1;
    send_item(REQ_SET, 10'h3ff, 32'hffff_ffff);
    while (waiting_count > 0) begin
      send_item(REQ_ADD, SLOT_W'($urandom_range(0, ENTRIES - 1)), $urandom);
    end
    repeat (3) send_item(REQ_ADD, SLOT_W'($urandom_range(0, ENTRIES - 1)), $urandom);
    send_item(REQ_UNUSED, 10'd0, 32'h0);
    send_item(REQ_REMOVE, 10'h3ff, $urandom);
    send_item(REQ_ADD, 10'd0, $urandom);
    send_item(REQ_ADD, 10'd0, $urandom);
  endtask

  task automatic test_free_list_full();
    gaps_on = 1'b1;
    while (waiting_count < ENTRIES) begin
      send_item(REQ_REMOVE, SLOT_W'($urandom_range(0, ENTRIES - 1)), $urandom);
    end
    repeat (3) send_item(REQ_REMOVE, SLOT_W'($urandom_range(0, ENTRIES - 1)), $urandom);
    send_item(REQ_SET, SLOT_W'($urandom_range(0, ENTRIES - 1)), $urandom);
    repeat (6) send_item(REQ_ADD, 10'd0, $urandom);
    send_item(REQ_REMOVE, 10'd0, $urandom);
  endtask

  task automatic test_tail_no_gaps(input int count);
    gaps_on = 1'b0;
    repeat (count) send_random(60);
  endtask

  task automatic finish_run();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (bad_results == 0) begin
      $display("id_slot_allocator test passed");
    end else begin
      $display("id_slot_allocator test failed");
    end
    $finish;
  endtask

  // result sink with bursty back-pressure
  always @(posedge clk) begin
    if (sink_hold > 0) sink_hold--;
    else if (gaps_on && $urandom_range(0, 7) == 0) sink_hold = $urandom_range(1, 18);
    out_ready <= (sink_hold == 0);
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_MAX) begin
          $display("unexpected result: id %0d status %0d hw %0d free %0d",
                   out_result_id, out_status, out_high_water, out_free_ids);
        end
      end else begin
        want = awaited_results.pop_front();
        if (out_result_id !== want.result_id || out_status !== want.status ||
            out_high_water !== want.high_water || out_free_ids !== want.free_ids) begin
          bad_results++;
          if (bad_results <= REPORT_MAX) begin
            $display("mismatch: expected id %0d status %0d hw %0d free %0d, got %0d %0d %0d %0d",
                     want.result_id, want.status, want.high_water, want.free_ids,
                     out_result_id, out_status, out_high_water, out_free_ids);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("id_slot_allocator test failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_requests();
    test_random_mix(36);
    test_no_free_id();
    test_free_list_full();
    test_tail_no_gaps(24);
    finish_run();
  end

endmodule
